@@ src/vrp_pkg.sv @@
// Shared widths, constants, register codes and stage records for the
// vertex rotate and project pipeline. No dependencies.
package vrp_pkg;

    localparam int COORD_W         = 16;
    localparam int TRIG_W          = 16;
    localparam int COORD_FRAC_BITS = 8;
    localparam int TRIG_FRAC_BITS  = 14;
    localparam int CENTRE_W        = 10;
    localparam int SCREEN_W        = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam int DIST_3D = 80;
    localparam int DIST_4D = 60;

    // Internal widths, sized from the worst-case magnitudes of each term
    localparam int PROD_W  = 2 * COORD_W;          // 16x16 product
    localparam int ROT1_W  = PROD_W + 1;           // sum of two products
    localparam int PROD2_W = ROT1_W + TRIG_W;      // first rotation times trig
    localparam int ROT2_W  = 48;                   // second rotation result
    localparam int DPRE_W  = ROT2_W + 1;           // offset denominator
    localparam int ZTERM_W = 51;                   // 60 * z << 28
    localparam int DEN_W   = 57;                   // signed denominator
    localparam int DMAG_W  = DEN_W - 1;
    localparam int NUM_W   = 61;                   // signed numerator
    localparam int MAG_W   = NUM_W - 1;
    localparam int KX_W    = 28;
    localparam int KY_W    = 14;
    localparam int QBITS   = 13;                   // quotient bits before clamp
    localparam int QSAT    = 4096;
    localparam int SUM_W   = 16;

    localparam int ROT_STAGES = 4;
    localparam int PRJ_STAGES = 3;
    localparam int DIV_STAGES = QBITS + 1;
    localparam int LATENCY    = ROT_STAGES + PRJ_STAGES + DIV_STAGES + 1;

    localparam int DEN_SHIFT  = COORD_FRAC_BITS + 2 * TRIG_FRAC_BITS;

    localparam logic signed [DPRE_W-1:0] DEN3_OFFSET =
        DPRE_W'(64'(DIST_3D) << DEN_SHIFT);
    localparam logic signed [DPRE_W-1:0] DEN4_OFFSET =
        DPRE_W'(64'(DIST_4D) << (DEN_SHIFT + TRIG_FRAC_BITS - TRIG_FRAC_BITS));
    localparam logic signed [KX_W-1:0] KX_3D =
        KX_W'(64'(DIST_3D) << TRIG_FRAC_BITS);
    localparam logic signed [KX_W-1:0] KX_4D =
        KX_W'(64'(DIST_3D * DIST_4D) << TRIG_FRAC_BITS);
    localparam logic signed [KY_W-1:0] KY_3D = KY_W'(DIST_3D);
    localparam logic signed [KY_W-1:0] KY_4D = KY_W'(DIST_3D * DIST_4D);

    localparam logic signed [SCREEN_W-1:0] SCREEN_MAX = {1'b0, {(SCREEN_W-1){1'b1}}};
    localparam logic signed [SCREEN_W-1:0] SCREEN_MIN = {1'b1, {(SCREEN_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOUR_D_MODE = 3'd0,
        REG_COS_FIRST   = 3'd1,
        REG_SIN_FIRST   = 3'd2,
        REG_COS_SECOND  = 3'd3,
        REG_SIN_SECOND  = 3'd4,
        REG_CENTRE_X    = 3'd5,
        REG_CENTRE_Y    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic                      four_d;
        logic signed [TRIG_W-1:0]  cos_first;
        logic signed [TRIG_W-1:0]  sin_first;
        logic signed [TRIG_W-1:0]  cos_second;
        logic signed [TRIG_W-1:0]  sin_second;
    } rot_cfg_t;

    typedef struct packed {
        logic                      valid;
        logic signed [ROT1_W-1:0]  x1;
        logic signed [ROT2_W-1:0]  y1;
        logic signed [ROT2_W-1:0]  r2;
        logic signed [COORD_W-1:0] z;
    } rot_out_t;

    typedef struct packed {
        logic               valid;
        logic               behind;
        logic               sign_x;
        logic               sign_y;
        logic [MAG_W-1:0]   mag_x;
        logic [MAG_W-1:0]   mag_y;
        logic [DMAG_W-1:0]  dmag;
    } div_in_t;

    typedef struct packed {
        logic               valid;
        logic               behind;
        logic               sign_x;
        logic               sign_y;
        logic               ovf_x;
        logic               ovf_y;
        logic [QBITS-1:0]   q_x;
        logic [QBITS-1:0]   q_y;
    } div_out_t;

endpackage

@@ src/vertex_rotate_project.sv @@
// Top level: configuration registers, rotation, projection, divider and
// screen placement stage. Depends on vrp_pkg, vrp_rotate, vrp_project, vrp_divider.
//
// Use: a vertex (coord_x/y/z/w, signed Q8.8) is taken on every clock edge at
// which start is high and busy is low. busy stays low, so one vertex per
// cycle is taken with no gaps. Each vertex gives one result beat: done is
// high for exactly one cycle with screen_x, screen_y and behind_viewer
// valid; the receiver cannot hold results off and must take every beat.
// A vertex passes through 4 rotation stages, 3 projection stages, 14
// divider stages (one per quotient bit plus an overflow check) and the
// output register before its result is taken. Throughput is one vertex
// per cycle, set by the fully pipelined divider.
// Configuration: cfg_we with cfg_index and cfg_data writes one register
// per edge; writes belong between streams, when no vertex is in flight.
// Asynchronous reset (rst_n low) empties the pipeline, drops done and
// loads the default rotation (identity), 3D mode and centre 120,67.
module vertex_rotate_project (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [vrp_pkg::COORD_W-1:0]      coord_x,
    input  logic signed [vrp_pkg::COORD_W-1:0]      coord_y,
    input  logic signed [vrp_pkg::COORD_W-1:0]      coord_z,
    input  logic signed [vrp_pkg::COORD_W-1:0]      coord_w,
    input  logic                                    cfg_we,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [vrp_pkg::CFG_DATA_W-1:0]          cfg_data,
    output logic                                    done,
    output logic signed [vrp_pkg::SCREEN_W-1:0]     screen_x,
    output logic signed [vrp_pkg::SCREEN_W-1:0]     screen_y,
    output logic                                    behind_viewer
);
    import vrp_pkg::*;

    rot_cfg_t               cfg_reg;
    logic [CENTRE_W-1:0]    centre_x_reg, centre_y_reg;

    rot_out_t               rot;
    div_in_t                dvin;
    div_out_t               dvout;

    logic                   done_reg;
    logic signed [SCREEN_W-1:0] screen_x_reg, screen_y_reg;
    logic                   behind_reg;

    logic signed [SCREEN_W-1:0] place_x_next, place_y_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.four_d     <= 1'b0;
            cfg_reg.cos_first  <= TRIG_W'(1 << TRIG_FRAC_BITS);
            cfg_reg.sin_first  <= '0;
            cfg_reg.cos_second <= TRIG_W'(1 << TRIG_FRAC_BITS);
            cfg_reg.sin_second <= '0;
            centre_x_reg       <= CENTRE_W'(120);
            centre_y_reg       <= CENTRE_W'(67);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FOUR_D_MODE: cfg_reg.four_d     <= cfg_data[0];
                REG_COS_FIRST:   cfg_reg.cos_first  <= cfg_data[TRIG_W-1:0];
                REG_SIN_FIRST:   cfg_reg.sin_first  <= cfg_data[TRIG_W-1:0];
                REG_COS_SECOND:  cfg_reg.cos_second <= cfg_data[TRIG_W-1:0];
                REG_SIN_SECOND:  cfg_reg.sin_second <= cfg_data[TRIG_W-1:0];
                REG_CENTRE_X:    centre_x_reg       <= cfg_data[CENTRE_W-1:0];
                REG_CENTRE_Y:    centre_y_reg       <= cfg_data[CENTRE_W-1:0];
                default: ;
            endcase
        end
    end

    vrp_rotate u_rotate (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (start && !busy),
        .x        (coord_x),
        .y        (coord_y),
        .z        (coord_z),
        .w        (coord_w),
        .out      (rot)
    );

    vrp_project u_project (
        .clk    (clk),
        .rst_n  (rst_n),
        .four_d (cfg_reg.four_d),
        .in     (rot),
        .out    (dvin)
    );

    vrp_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (dvin),
        .out   (dvout)
    );

    // clamp quotient to +-QSAT, apply sign, add centre, saturate to screen
    function automatic logic signed [SCREEN_W-1:0] place(
        input logic             ovf,
        input logic             sgn,
        input logic [QBITS-1:0] q,
        input logic [CENTRE_W-1:0] centre
    );
        logic [QBITS:0]          mag;
        logic signed [SUM_W-1:0] sum;
        if (ovf || (q > QBITS'(QSAT)))
            mag = (QBITS+1)'(QSAT);
        else
            mag = {1'b0, q};
        sum = sgn ? SUM_W'(centre) - SUM_W'(mag) : SUM_W'(centre) + SUM_W'(mag);
        priority if (sum > SUM_W'(SCREEN_MAX))
            place = SCREEN_MAX;
        else if (sum < SUM_W'(SCREEN_MIN))
            place = SCREEN_MIN;
        else
            place = sum[SCREEN_W-1:0];
    endfunction

    always_comb
    begin
        place_x_next = place(dvout.ovf_x, dvout.sign_x, dvout.q_x, centre_x_reg);
        place_y_next = place(dvout.ovf_y, dvout.sign_y, dvout.q_y, centre_y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dvout.valid;
    end

    always_ff @(posedge clk)
    begin
        behind_reg   <= dvout.behind;
        screen_x_reg <= dvout.behind ? '0 : place_x_next;
        screen_y_reg <= dvout.behind ? '0 : place_y_next;
    end

    assign done          = done_reg;
    assign screen_x      = screen_x_reg;
    assign screen_y      = screen_y_reg;
    assign behind_viewer = behind_reg;

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result beat without an accepted vertex");

    a_behind_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && behind_viewer) |-> (screen_x == '0 && screen_y == '0))
        else $error("flagged vertex with non-zero position");

endmodule

@@ src/vrp_rotate.sv @@
// Two-plane rotation of a vertex over four register stages.
// Depends on vrp_pkg.
module vrp_rotate (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  vrp_pkg::rot_cfg_t                    cfg,
    input  logic                                 in_valid,
    input  logic signed [vrp_pkg::COORD_W-1:0]   x,
    input  logic signed [vrp_pkg::COORD_W-1:0]   y,
    input  logic signed [vrp_pkg::COORD_W-1:0]   z,
    input  logic signed [vrp_pkg::COORD_W-1:0]   w,
    output vrp_pkg::rot_out_t                    out
);
    import vrp_pkg::*;

    // stage 1: products
    logic                       s1_valid_reg;
    logic signed [PROD_W-1:0]   xc_reg, xs_reg, oc_reg, os_reg, yc_reg, ys_reg;
    logic signed [COORD_W-1:0]  s1_z_reg;
    // stage 2: first rotation
    logic                       s2_valid_reg;
    logic signed [ROT1_W-1:0]   s2_x1_reg, s2_r1_reg;
    logic signed [PROD_W-1:0]   s2_yc_reg, s2_ys_reg;
    logic signed [COORD_W-1:0]  s2_z_reg;
    // stage 3: second products
    logic                       s3_valid_reg;
    logic signed [PROD2_W-1:0]  r1s_reg, r1c_reg;
    logic signed [ROT1_W-1:0]   s3_x1_reg;
    logic signed [PROD_W-1:0]   s3_yc_reg, s3_ys_reg;
    logic signed [COORD_W-1:0]  s3_z_reg;
    // stage 4
    logic                       s4_valid_reg;
    logic signed [ROT1_W-1:0]   s4_x1_reg;
    logic signed [ROT2_W-1:0]   s4_y1_reg, s4_r2_reg;
    logic signed [COORD_W-1:0]  s4_z_reg;

    logic signed [COORD_W-1:0]  other;
    logic signed [ROT1_W-1:0]   x1_next, r1_next;
    logic signed [ROT2_W-1:0]   y1_next, r2_next;

    // the partner of x is w in 4D mode and z in 3D mode
    assign other = cfg.four_d ? w : z;

    always_comb
    begin
        if (cfg.four_d)
        begin
            x1_next = ROT1_W'(xc_reg) - ROT1_W'(os_reg);
            r1_next = ROT1_W'(oc_reg) + ROT1_W'(xs_reg);
        end
        else
        begin
            x1_next = ROT1_W'(xc_reg) + ROT1_W'(os_reg);
            r1_next = ROT1_W'(oc_reg) - ROT1_W'(xs_reg);
        end
        y1_next = (ROT2_W'(s3_yc_reg) <<< TRIG_FRAC_BITS) - ROT2_W'(r1s_reg);
        r2_next = (ROT2_W'(s3_ys_reg) <<< TRIG_FRAC_BITS) + ROT2_W'(r1c_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        xc_reg   <= x * cfg.cos_first;
        xs_reg   <= x * cfg.sin_first;
        oc_reg   <= other * cfg.cos_first;
        os_reg   <= other * cfg.sin_first;
        yc_reg   <= y * cfg.cos_second;
        ys_reg   <= y * cfg.sin_second;
        s1_z_reg <= z;

        s2_x1_reg <= x1_next;
        s2_r1_reg <= r1_next;
        s2_yc_reg <= yc_reg;
        s2_ys_reg <= ys_reg;
        s2_z_reg  <= s1_z_reg;

        r1s_reg   <= PROD2_W'(s2_r1_reg) * PROD2_W'(cfg.sin_second);
        r1c_reg   <= PROD2_W'(s2_r1_reg) * PROD2_W'(cfg.cos_second);
        s3_x1_reg <= s2_x1_reg;
        s3_yc_reg <= s2_yc_reg;
        s3_ys_reg <= s2_ys_reg;
        s3_z_reg  <= s2_z_reg;

        s4_x1_reg <= s3_x1_reg;
        s4_y1_reg <= y1_next;
        s4_r2_reg <= r2_next;
        s4_z_reg  <= s3_z_reg;
    end

    assign out = '{valid: s4_valid_reg, x1: s4_x1_reg, y1: s4_y1_reg,
                   r2: s4_r2_reg, z: s4_z_reg};

endmodule

@@ src/vrp_project.sv @@
// Perspective numerators and denominator, then sign and magnitude split
// for the divider; three register stages. Depends on vrp_pkg.
module vrp_project (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               four_d,
    input  vrp_pkg::rot_out_t  in,
    output vrp_pkg::div_in_t   out
);
    import vrp_pkg::*;

    logic                       s5_valid_reg;
    logic signed [DPRE_W-1:0]   dpre_reg;
    logic signed [ZTERM_W-1:0]  zterm_reg;
    logic signed [NUM_W-1:0]    s5_numx_reg, s5_numy_reg;

    logic                       s6_valid_reg;
    logic signed [DEN_W-1:0]    den_reg;
    logic signed [NUM_W-1:0]    s6_numx_reg, s6_numy_reg;

    logic                       s7_valid_reg;
    logic                       s7_behind_reg;
    logic                       s7_sign_x_reg, s7_sign_y_reg;
    logic [MAG_W-1:0]           s7_mag_x_reg, s7_mag_y_reg;
    logic [DMAG_W-1:0]          s7_dmag_reg;

    logic signed [DPRE_W-1:0]   dpre_next;
    logic signed [DEN_W-1:0]    den_next;
    logic signed [KX_W-1:0]     kx;
    logic signed [KY_W-1:0]     ky;
    logic signed [NUM_W-1:0]    negx, negy;

    assign kx = four_d ? KX_4D : KX_3D;
    assign ky = four_d ? KY_4D : KY_3D;

    always_comb
    begin
        dpre_next = four_d ? (DEN4_OFFSET << TRIG_FRAC_BITS - TRIG_FRAC_BITS) - DPRE_W'(in.r2)
                           : DPRE_W'(in.r2) + DEN3_OFFSET;
        if (!four_d)
            den_next = DEN_W'(dpre_reg);
        else if (dpre_reg > 0)
            den_next = DEN_W'(dpre_reg) * DEN_W'(DIST_3D) - DEN_W'(zterm_reg);
        else
            den_next = '0;
        negx = -s6_numx_reg;
        negy = -s6_numy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= in.valid;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dpre_reg    <= dpre_next;
        zterm_reg   <= (ZTERM_W'(in.z) * ZTERM_W'(DIST_4D)) <<< (2 * TRIG_FRAC_BITS);
        s5_numx_reg <= NUM_W'(in.x1) * NUM_W'(kx);
        s5_numy_reg <= NUM_W'(in.y1) * NUM_W'(ky);

        den_reg     <= den_next;
        s6_numx_reg <= s5_numx_reg;
        s6_numy_reg <= s5_numy_reg;

        s7_behind_reg <= den_reg[DEN_W-1] || (den_reg == '0);
        s7_dmag_reg   <= den_reg[DMAG_W-1:0];
        s7_sign_x_reg <= s6_numx_reg[NUM_W-1];
        s7_sign_y_reg <= s6_numy_reg[NUM_W-1];
        s7_mag_x_reg  <= s6_numx_reg[NUM_W-1] ? negx[MAG_W-1:0] : s6_numx_reg[MAG_W-1:0];
        s7_mag_y_reg  <= s6_numy_reg[NUM_W-1] ? negy[MAG_W-1:0] : s6_numy_reg[MAG_W-1:0];
    end

    assign out = '{valid: s7_valid_reg, behind: s7_behind_reg,
                   sign_x: s7_sign_x_reg, sign_y: s7_sign_y_reg,
                   mag_x: s7_mag_x_reg, mag_y: s7_mag_y_reg, dmag: s7_dmag_reg};

    // a 4D vertex past the w plane must come out flagged
    a_behind_w : assert property (@(posedge clk) disable iff (!rst_n)
        (s5_valid_reg && four_d && (dpre_reg <= 0)) |-> ##2 (s7_valid_reg && s7_behind_reg))
        else $error("w-plane denominator not flagged");

endmodule

@@ src/vrp_divider.sv @@
// Pipelined restoring divider: overflow check, then one quotient bit per
// stage for both coordinates over a shared denominator. Depends on vrp_pkg.
module vrp_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  vrp_pkg::div_in_t   in,
    output vrp_pkg::div_out_t  out
);
    import vrp_pkg::*;

    localparam int CMP_W = MAG_W + QBITS;

    typedef struct packed {
        logic               valid;
        logic               behind;
        logic               sign_x;
        logic               sign_y;
        logic               ovf_x;
        logic               ovf_y;
        logic [MAG_W-1:0]   rem_x;
        logic [MAG_W-1:0]   rem_y;
        logic [DMAG_W-1:0]  dmag;
        logic [QBITS-1:0]   q_x;
        logic [QBITS-1:0]   q_y;
    } div_stage_t;

    div_stage_t        stage_reg [0:QBITS];
    logic [CMP_W-1:0]  dtop;

    // quotient would not fit in QBITS bits: saturates anyway
    assign dtop = CMP_W'(in.dmag) << QBITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg[0] <= '0;
        else
        begin
            stage_reg[0].valid  <= in.valid;
            stage_reg[0].behind <= in.behind;
            stage_reg[0].sign_x <= in.sign_x;
            stage_reg[0].sign_y <= in.sign_y;
            stage_reg[0].ovf_x  <= CMP_W'(in.mag_x) >= dtop;
            stage_reg[0].ovf_y  <= CMP_W'(in.mag_y) >= dtop;
            stage_reg[0].rem_x  <= in.mag_x;
            stage_reg[0].rem_y  <= in.mag_y;
            stage_reg[0].dmag   <= in.dmag;
            stage_reg[0].q_x    <= '0;
            stage_reg[0].q_y    <= '0;
        end
    end

    for (genvar s = 0; s < QBITS; s++)
    begin : g_step
        localparam int SH = QBITS - 1 - s;
        logic [CMP_W-1:0] dsh;
        logic             take_x, take_y;
        div_stage_t       step_next;

        always_comb
        begin
            dsh       = CMP_W'(stage_reg[s].dmag) << SH;
            take_x    = CMP_W'(stage_reg[s].rem_x) >= dsh;
            take_y    = CMP_W'(stage_reg[s].rem_y) >= dsh;
            step_next = stage_reg[s];
            if (take_x)
            begin
                step_next.rem_x   = stage_reg[s].rem_x - dsh[MAG_W-1:0];
                step_next.q_x[SH] = 1'b1;
            end
            if (take_y)
            begin
                step_next.rem_y   = stage_reg[s].rem_y - dsh[MAG_W-1:0];
                step_next.q_y[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                stage_reg[s+1] <= '0;
            else
                stage_reg[s+1] <= step_next;
        end
    end

    assign out.valid  = stage_reg[QBITS].valid;
    assign out.behind = stage_reg[QBITS].behind;
    assign out.sign_x = stage_reg[QBITS].sign_x;
    assign out.sign_y = stage_reg[QBITS].sign_y;
    assign out.ovf_x  = stage_reg[QBITS].ovf_x;
    assign out.ovf_y  = stage_reg[QBITS].ovf_y;
    assign out.q_x    = stage_reg[QBITS].q_x;
    assign out.q_y    = stage_reg[QBITS].q_y;

    a_div_latency : assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> $past(in.valid, DIV_STAGES))
        else $error("divider beat without matching input");

endmodule
